// ===== src/psx_pkg.sv =====
// Shared types and constants for the probe request SSID extractor.
`timescale 1ns / 1ps
`default_nettype none

package psx_pkg;

   localparam int HEADER_BYTES = 24;
   localparam int NAME_LIMIT   = 32;

   localparam int HDR_POS_W = 5;
   localparam int MAC_W     = 48;

   localparam logic [HDR_POS_W-1:0] ADDR_FIRST_POS = HDR_POS_W'(10);
   localparam logic [HDR_POS_W-1:0] ADDR_LAST_POS  = HDR_POS_W'(15);

   localparam logic [1:0] TYPE_MASK     = 2'h3;
   localparam logic [3:0] SUBTYPE_MASK  = 4'hF;
   localparam logic [1:0] TYPE_MGMT     = 2'd0;
   localparam logic [3:0] SUBTYPE_PROBE = 4'd4;
   localparam logic [7:0] ELEM_ID_SSID  = 8'd0;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } psx_req_type;

   typedef struct packed {
      logic [7:0]       ssid_byte;
      logic [MAC_W-1:0] source_mac;
      logic             ssid_end;
      logic             cut_short;
   } psx_rsp_type;

endpackage

`default_nettype wire

// ===== src/psx_parser.sv =====
// Byte-wise frame parser: header check, address capture, element walk, SSID emit.
`timescale 1ns / 1ps
`default_nettype none

module psx_parser
   import psx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_fire,
   input  wire psx_req_type in_data,
   output logic             res_valid,
   output psx_rsp_type      res_data
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_ID,
      PH_LEN,
      PH_SKIP,
      PH_SSID,
      PH_DONE
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [HDR_POS_W-1:0]   pos_ff, pos_in;
   logic                   probe_ff, probe_in;
   logic [MAC_W-1:0]       sender_ff, sender_in;
   logic [7:0]             elem_id_ff, elem_id_in;
   logic [7:0]             remain_ff, remain_in;

   logic [7:0]             b;
   logic                   probe_now;
   logic                   natural_end;
   logic [7:0]             remain_dec;
   logic [HDR_POS_W:0]     pos_next;

   assign b           = in_data.frame_byte;
   assign remain_dec  = remain_ff - 8'd1;
   assign natural_end = (remain_ff <= 8'd1);
   assign pos_next    = {1'b0, pos_ff} + (HDR_POS_W+1)'(1);

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      probe_in   = probe_ff;
      sender_in  = sender_ff;
      elem_id_in = elem_id_ff;
      remain_in  = remain_ff;
      res_valid  = 1'b0;
      probe_now  = probe_ff;

      res_data.ssid_byte  = b;
      res_data.source_mac = sender_ff;
      res_data.ssid_end   = natural_end | in_data.last_byte;
      res_data.cut_short  = ~natural_end & in_data.last_byte;

      if (in_fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == '0) begin
                  probe_now = ((b[3:2] & TYPE_MASK) == TYPE_MGMT) &&
                              ((b[7:4] & SUBTYPE_MASK) == SUBTYPE_PROBE);
                  probe_in  = probe_now;
               end
               if (pos_ff >= ADDR_FIRST_POS && pos_ff <= ADDR_LAST_POS) begin
                  sender_in = {sender_ff[MAC_W-9:0], b};
               end
               if (!probe_now) begin
                  phase_in = PH_DONE;
               end else if (pos_next >= (HDR_POS_W+1)'(HEADER_BYTES)) begin
                  phase_in = PH_ID;
               end else begin
                  pos_in = pos_next[HDR_POS_W-1:0];
               end
            end
            PH_ID: begin
               elem_id_in = b;
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               if (elem_id_ff == ELEM_ID_SSID) begin
                  if (b == 8'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     remain_in = (b > 8'(NAME_LIMIT)) ? 8'(NAME_LIMIT) : b;
                     phase_in  = PH_SSID;
                  end
               end else begin
                  remain_in = b;
                  phase_in  = (b == 8'd0) ? PH_ID : PH_SKIP;
               end
            end
            PH_SKIP: begin
               remain_in = remain_dec;
               if (remain_dec == 8'd0) begin
                  phase_in = PH_ID;
               end
            end
            PH_SSID: begin
               remain_in = remain_dec;
               res_valid = 1'b1;
               if (natural_end) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase

         // Restart for the next frame after its final byte.
         if (in_data.last_byte) begin
            phase_in = PH_HEADER;
            pos_in   = '0;
            probe_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         probe_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         probe_ff <= probe_in;
      end
      sender_ff  <= sender_in;
      elem_id_ff <= elem_id_in;
      remain_ff  <= remain_in;
   end

endmodule

`default_nettype wire

// ===== src/psx_skid.sv =====
// Result register with a skid stage so input acceptance does not wait on rsp_ready.
`timescale 1ns / 1ps
`default_nettype none

module psx_skid
   import psx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire psx_rsp_type in_data,
   output logic             space,
   output logic             out_valid,
   output psx_rsp_type      out_data,
   input  wire logic        out_ready
);

   logic        out_valid_ff, out_valid_in;
   psx_rsp_type out_data_ff, out_data_in;
   logic        skid_valid_ff, skid_valid_in;
   psx_rsp_type skid_data_ff, skid_data_in;
   logic        pop;

   assign pop       = out_valid_ff & out_ready;
   assign space     = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // Advance the held transfer once the output drains.
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

// ===== src/probe_request_ssid_extractor.sv =====
// Top level of the probe request SSID extractor.
`timescale 1ns / 1ps
`default_nettype none

// Feed a received 802.11 frame one byte per transfer on req_, starting at the
// frame control field, with last_byte set on the final byte. Only management
// probe requests are parsed; the transmitter address (header bytes 10 to 15)
// is captured, the header is skipped and the information elements are walked
// up to the first SSID element. Each SSID byte, at most NAME_LIMIT of them,
// comes out as one rsp_ transfer carrying the captured address; ssid_end marks
// the final one and cut_short flags a frame that ended inside the element.
// A zero-length SSID, a short frame or a non-probe frame produces nothing.
// One byte is taken every clock cycle while req_ready is high: the parser
// state updates on each accepted byte, and results pass through an output
// register with a one-entry skid, so req_ready drops only when both hold an
// unread result. A result waits in the skid while the output register is full.

module probe_request_ssid_extractor
   import psx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire psx_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output psx_rsp_type      rsp_data
);

   logic        req_fire;
   logic        res_valid;
   psx_rsp_type res_data;
   logic        space;

   // Accept a byte whenever the skid stage is free.
   assign req_ready = space;
   assign req_fire  = req_valid & space;

   psx_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (req_fire),
      .in_data   (req_data),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // Hold results until the consumer takes them.
   psx_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .space     (space),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (rsp_ready)
   );

endmodule

`default_nettype wire

// ===== src/psx_checker.sv =====
// Port-level checks for the probe request SSID extractor, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module psx_checker
   import psx_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire psx_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_cut_implies_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cut_short |-> rsp_data.ssid_end)
      else $error("cut_short without ssid_end");

   a_new_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result appeared without an accepted byte");

   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind probe_request_ssid_extractor psx_checker u_psx_checker (.*);

`default_nettype wire
